// ===== src/rdba_pkg.sv =====
// Shared types, codes and constants for the rover drive and bump avoidance block.
package rdba_pkg;

    // Encoder counter width and pulses per centimeter
    localparam int COUNT_WIDTH   = 32;
    localparam int PULSES_PER_CM = 80;
    localparam int REM_WIDTH     = $clog2(PULSES_PER_CM + 1);
    localparam int DIST_WIDTH    = 16;

    // Configuration port geometry
    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    // Reset values of the configuration registers
    localparam logic [7:0]  SPEED_LOW_RST       = 8'd50;
    localparam logic [7:0]  SPEED_MID_RST       = 8'd125;
    localparam logic [7:0]  SPEED_HIGH_RST      = 8'd175;
    localparam logic [7:0]  RAMP_START_RST      = 8'd10;
    localparam logic [15:0] AVOID_DISTANCE_RST  = 16'd15;
    localparam logic [7:0]  BLINK_THRESHOLD_RST = 8'd32;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SPEED_LOW       = 3'd0,
        REG_SPEED_MID       = 3'd1,
        REG_SPEED_HIGH      = 3'd2,
        REG_RAMP_START      = 3'd3,
        REG_AVOID_DISTANCE  = 3'd4,
        REG_BLINK_THRESHOLD = 3'd5
    } reg_index_t;

    // Event kinds
    typedef enum logic [2:0] {
        OP_COMMAND     = 3'd0,
        OP_RAMP_TICK   = 3'd1,
        OP_BLINK_TICK  = 3'd2,
        OP_LEFT_PULSE  = 3'd3,
        OP_RIGHT_PULSE = 3'd4,
        OP_CONTROL     = 3'd5
    } opcode_t;

    // Headings
    localparam logic [1:0] HD_FWD   = 2'd0;
    localparam logic [1:0] HD_LEFT  = 2'd1;
    localparam logic [1:0] HD_REV   = 2'd2;
    localparam logic [1:0] HD_RIGHT = 2'd3;

    // Command characters
    localparam logic [7:0] CMD_FWD   = 8'h77; // 'w'
    localparam logic [7:0] CMD_LEFT  = 8'h61; // 'a'
    localparam logic [7:0] CMD_REV   = 8'h73; // 's'
    localparam logic [7:0] CMD_RIGHT = 8'h64; // 'd'
    localparam logic [7:0] CMD_LOW   = 8'h31; // '1'
    localparam logic [7:0] CMD_MID   = 8'h32; // '2'
    localparam logic [7:0] CMD_HIGH  = 8'h33; // '3'
    localparam logic [7:0] CMD_ZERO  = 8'h71; // 'q'
    localparam logic [7:0] CMD_STOP  = 8'h38; // '8'

    // Manoeuvre phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_REVERSE  = 3'd1;
    localparam logic [2:0] PH_TURN     = 3'd2;
    localparam logic [2:0] PH_FORWARD  = 3'd3;
    localparam logic [2:0] PH_TURNBACK = 3'd4;

    // Result word width: 34 payload bits padded to whole bytes
    localparam int RESULT_WIDTH = 40;

    // Direction pins for a heading: bit0 left reverse, bit1 right reverse
    function automatic logic [1:0] heading_pins(input logic [1:0] hd);
        logic [1:0] pins;
        case (hd)
            HD_FWD:   pins = 2'd0;
            HD_LEFT:  pins = 2'd1;
            HD_REV:   pins = 2'd3;
            HD_RIGHT: pins = 2'd2;
            default:  pins = 2'd0;
        endcase
        return pins;
    endfunction

endpackage

// ===== src/rover_drive_and_bump_avoidance.sv =====
// Top level of the rover drive and bump avoidance controller.
//
// Each input transfer carries one event (command byte, ramp tick, blink tick, left or
// right encoder pulse, control pass) and yields exactly one result transfer holding all
// outputs after that event. The block takes one event per cycle while s_tready is high; the
// result is registered before the master side sees it. A two-entry output buffer lets the
// block keep taking events while a result waits, and s_tready drops only when both
// entries are full. Distance is kept as a running quotient and remainder of the pulse
// sum, so no divider is needed. Configuration is written over the APB-style port.
module rover_drive_and_bump_avoidance
    import rdba_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Event stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [15:0]             s_tdata,   // [7:0] cmd_byte, [8] bump_right, [9] bump_left
    input  logic [2:0]              s_tuser,   // [2:0] opcode
    // Result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [RESULT_WIDTH-1:0] m_tdata,   // [1:0] dir_pins, [2] left_light,
                                               // [3] right_light, [11:4] motor_duty,
                                               // [27:12] distance_cm, [29:28] heading,
                                               // [32:30] avoid_phase, [33] avoiding
    // Configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_WIDTH-1:0]   paddr,
    input  logic [DATA_WIDTH-1:0]   pwdata,
    output logic [DATA_WIDTH-1:0]   prdata,
    output logic                    pready
);

    // Configuration registers
    logic [7:0]  speed_low_reg, speed_mid_reg, speed_high_reg, ramp_start_reg;
    logic [15:0] avoid_distance_reg;
    logic [7:0]  blink_threshold_reg;

    // Controller state
    logic [1:0]             heading_reg, heading_next;
    logic                   dirty_reg, dirty_next;
    logic [1:0]             pin_reg, pin_next;
    logic [7:0]             blink_reg, blink_next;
    logic [1:0]             lights_reg, lights_next;
    logic [7:0]             duty_now_reg, duty_now_next;
    logic [7:0]             duty_target_reg, duty_target_next;
    logic                   ramp_pending_reg, ramp_pending_next;
    logic [7:0]             pwm_reg, pwm_next;
    logic [COUNT_WIDTH-1:0] sum_reg, sum_next;
    logic [REM_WIDTH-1:0]   rem_reg, rem_next;
    logic [DIST_WIDTH-1:0]  dist_reg, dist_next;
    logic                   latched_reg, latched_next;
    logic                   side_right_reg, side_right_next;
    logic [2:0]             phase_reg, phase_next;
    logic [DIST_WIDTH-1:0]  mark_reg [4];
    logic [DIST_WIDTH-1:0]  mark_next [4];

    // Output buffer
    logic                    out_valid_reg, out_valid_next;
    logic [RESULT_WIDTH-1:0] out_data_reg, out_data_next;
    logic                    skid_valid_reg, skid_valid_next;
    logic [RESULT_WIDTH-1:0] skid_data_reg, skid_data_next;
    logic [RESULT_WIDTH-1:0] result;

    logic    in_xfer, out_xfer, cfg_write;
    opcode_t opcode;
    logic [7:0] cmd_byte;
    logic    bump_right, bump_left;

    assign opcode     = opcode_t'(s_tuser);
    assign cmd_byte   = s_tdata[7:0];
    assign bump_right = s_tdata[8];
    assign bump_left  = s_tdata[9];

    assign s_tready  = ~skid_valid_reg;
    assign in_xfer   = s_tvalid & s_tready;
    assign out_xfer  = m_tvalid & m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    // Signed distance test: (cm - mark) > avoid_distance
    function automatic logic passed(input logic [DIST_WIDTH-1:0] cm,
                                    input logic [DIST_WIDTH-1:0] mark,
                                    input logic [15:0] limit);
        logic signed [DIST_WIDTH+1:0] diff;
        diff = signed'({2'b00, cm}) - signed'({2'b00, mark});
        return diff > signed'({2'b00, limit});
    endfunction

    // Configuration write
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            speed_low_reg       <= SPEED_LOW_RST;
            speed_mid_reg       <= SPEED_MID_RST;
            speed_high_reg      <= SPEED_HIGH_RST;
            ramp_start_reg      <= RAMP_START_RST;
            avoid_distance_reg  <= AVOID_DISTANCE_RST;
            blink_threshold_reg <= BLINK_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(paddr[4:2]))
                REG_SPEED_LOW:       speed_low_reg       <= pwdata[7:0];
                REG_SPEED_MID:       speed_mid_reg       <= pwdata[7:0];
                REG_SPEED_HIGH:      speed_high_reg      <= pwdata[7:0];
                REG_RAMP_START:      ramp_start_reg      <= pwdata[7:0];
                REG_AVOID_DISTANCE:  avoid_distance_reg  <= pwdata[15:0];
                REG_BLINK_THRESHOLD: blink_threshold_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Configuration read
    always_comb
    begin
        case (reg_index_t'(paddr[4:2]))
            REG_SPEED_LOW:       prdata = {24'd0, speed_low_reg};
            REG_SPEED_MID:       prdata = {24'd0, speed_mid_reg};
            REG_SPEED_HIGH:      prdata = {24'd0, speed_high_reg};
            REG_RAMP_START:      prdata = {24'd0, ramp_start_reg};
            REG_AVOID_DISTANCE:  prdata = {16'd0, avoid_distance_reg};
            REG_BLINK_THRESHOLD: prdata = {24'd0, blink_threshold_reg};
            default:             prdata = '0;
        endcase
    end

    // Apply one event to the controller state
    always_comb
    begin
        logic [8:0] ramp_sum;
        logic [1:0] new_hd;
        logic       hd_set;

        heading_next      = heading_reg;
        dirty_next        = dirty_reg;
        pin_next          = pin_reg;
        blink_next        = blink_reg;
        lights_next       = lights_reg;
        duty_now_next     = duty_now_reg;
        duty_target_next  = duty_target_reg;
        ramp_pending_next = ramp_pending_reg;
        pwm_next          = pwm_reg;
        sum_next          = sum_reg;
        rem_next          = rem_reg;
        dist_next         = dist_reg;
        latched_next      = latched_reg;
        side_right_next   = side_right_reg;
        phase_next        = phase_reg;
        mark_next         = mark_reg;
        ramp_sum          = '0;
        new_hd            = HD_FWD;
        hd_set            = 1'b0;

        case (opcode)
            OP_COMMAND:
            begin
                case (cmd_byte)
                    CMD_FWD:   begin new_hd = HD_FWD;   hd_set = 1'b1; end
                    CMD_LEFT:  begin new_hd = HD_LEFT;  hd_set = 1'b1; end
                    CMD_REV:   begin new_hd = HD_REV;   hd_set = 1'b1; end
                    CMD_RIGHT: begin new_hd = HD_RIGHT; hd_set = 1'b1; end
                    CMD_LOW:
                        if (duty_target_reg != speed_low_reg)
                        begin
                            duty_target_next  = speed_low_reg;
                            ramp_pending_next = 1'b1;
                        end
                    CMD_MID:
                        if (duty_target_reg != speed_mid_reg)
                        begin
                            duty_target_next  = speed_mid_reg;
                            ramp_pending_next = 1'b1;
                        end
                    CMD_HIGH:
                        if (duty_target_reg != speed_high_reg)
                        begin
                            duty_target_next  = speed_high_reg;
                            ramp_pending_next = 1'b1;
                        end
                    CMD_ZERO:
                        if (duty_target_reg != 8'd0)
                        begin
                            duty_target_next  = 8'd0;
                            ramp_pending_next = 1'b1;
                        end
                    CMD_STOP:
                    begin
                        duty_target_next = 8'd0;
                        duty_now_next    = 8'd0;
                        pwm_next         = 8'd0;
                    end
                    default: ;
                endcase
                if (hd_set && new_hd != heading_reg)
                begin
                    heading_next = new_hd;
                    dirty_next   = 1'b1;
                    blink_next   = blink_threshold_reg;
                end
            end

            OP_RAMP_TICK:
                if (ramp_pending_reg)
                begin
                    // Step toward the target, jumping off zero first
                    if (duty_now_reg > duty_target_reg)
                        duty_now_next = duty_now_reg - 8'd1;
                    else
                    begin
                        ramp_sum = (duty_now_reg == 8'd0) ? {1'b0, ramp_start_reg} + 9'd1
                                                          : {1'b0, duty_now_reg} + 9'd1;
                        duty_now_next = ramp_sum[8] ? 8'hFF : ramp_sum[7:0];
                    end
                    if (duty_now_next == duty_target_reg)
                        ramp_pending_next = 1'b0;
                    pwm_next = duty_now_next;
                end

            OP_BLINK_TICK:
                if (blink_reg != 8'hFF)
                    blink_next = blink_reg + 8'd1;

            OP_LEFT_PULSE, OP_RIGHT_PULSE:
            begin
                // Count the pulse; the quotient steps up when the remainder wraps
                if (&sum_reg)
                begin
                    sum_next  = '0;
                    rem_next  = '0;
                    dist_next = '0;
                end
                else
                begin
                    sum_next = sum_reg + COUNT_WIDTH'(1);
                    if (rem_reg == REM_WIDTH'(PULSES_PER_CM - 1))
                    begin
                        rem_next  = '0;
                        dist_next = dist_reg + DIST_WIDTH'(1);
                    end
                    else
                        rem_next = rem_reg + REM_WIDTH'(1);
                end
            end

            OP_CONTROL:
            begin
                // Advance the manoeuvre
                if (latched_reg)
                begin
                    if (heading_reg != HD_REV && phase_reg == PH_IDLE)
                    begin
                        new_hd       = HD_REV;
                        hd_set       = 1'b1;
                        mark_next[0] = dist_reg;
                        phase_next   = PH_REVERSE;
                    end
                    else if (phase_reg == PH_REVERSE
                             && passed(dist_reg, mark_reg[0], avoid_distance_reg))
                    begin
                        new_hd       = side_right_reg ? HD_LEFT : HD_RIGHT;
                        hd_set       = 1'b1;
                        mark_next[1] = dist_reg;
                        phase_next   = PH_TURN;
                    end
                    else if (phase_reg == PH_TURN
                             && passed(dist_reg, mark_reg[1], avoid_distance_reg))
                    begin
                        new_hd       = HD_FWD;
                        hd_set       = 1'b1;
                        mark_next[2] = dist_reg;
                        phase_next   = PH_FORWARD;
                    end
                    else if (phase_reg == PH_FORWARD
                             && passed(dist_reg, mark_reg[2], avoid_distance_reg))
                    begin
                        new_hd       = side_right_reg ? HD_RIGHT : HD_LEFT;
                        hd_set       = 1'b1;
                        mark_next[3] = dist_reg;
                        phase_next   = PH_TURNBACK;
                    end
                    else if (phase_reg == PH_TURNBACK
                             && passed(dist_reg, mark_reg[3], avoid_distance_reg))
                    begin
                        new_hd       = HD_FWD;
                        hd_set       = 1'b1;
                        phase_next   = PH_IDLE;
                        latched_next = 1'b0;
                    end
                end
                if (hd_set && new_hd != heading_reg)
                begin
                    heading_next = new_hd;
                    dirty_next   = 1'b1;
                    blink_next   = blink_threshold_reg;
                end

                // Drive the direction pins once the heading has ever changed
                if (dirty_next)
                    pin_next = heading_pins(heading_next);

                // Toggle or clear the turn lights
                if (blink_next > blink_threshold_reg)
                begin
                    if (duty_now_reg != 8'd0 && heading_next == HD_LEFT)
                        lights_next = {1'b0, ~lights_reg[0]};
                    else if (duty_now_reg != 8'd0 && heading_next == HD_RIGHT)
                        lights_next = {~lights_reg[1], 1'b0};
                    else
                        lights_next = 2'b00;
                    blink_next = 8'd0;
                end

                if (ramp_pending_reg)
                    pwm_next = duty_now_reg;

                // Latch a new bump; right side wins
                if (!latched_next && (bump_right || bump_left))
                begin
                    side_right_next = bump_right;
                    latched_next    = 1'b1;
                end
            end

            default: ;
        endcase
    end

    // Pack the result from the updated state
    assign result = {6'd0, latched_next, phase_next, heading_next, dist_next, pwm_next,
                     lights_next[1], lights_next[0], pin_next};

    // Hold state; advance it on each input transfer
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            heading_reg      <= HD_FWD;
            dirty_reg        <= 1'b0;
            pin_reg          <= 2'd0;
            blink_reg        <= 8'd0;
            lights_reg       <= 2'd0;
            duty_now_reg     <= 8'd0;
            duty_target_reg  <= 8'd0;
            ramp_pending_reg <= 1'b0;
            pwm_reg          <= 8'd0;
            sum_reg          <= '0;
            rem_reg          <= '0;
            dist_reg         <= '0;
            latched_reg      <= 1'b0;
            side_right_reg   <= 1'b0;
            phase_reg        <= PH_IDLE;
            for (int i = 0; i < 4; i++)
                mark_reg[i] <= '0;
        end
        else if (in_xfer)
        begin
            heading_reg      <= heading_next;
            dirty_reg        <= dirty_next;
            pin_reg          <= pin_next;
            blink_reg        <= blink_next;
            lights_reg       <= lights_next;
            duty_now_reg     <= duty_now_next;
            duty_target_reg  <= duty_target_next;
            ramp_pending_reg <= ramp_pending_next;
            pwm_reg          <= pwm_next;
            sum_reg          <= sum_next;
            rem_reg          <= rem_next;
            dist_reg         <= dist_next;
            latched_reg      <= latched_next;
            side_right_reg   <= side_right_next;
            phase_reg        <= phase_next;
            mark_reg         <= mark_next;
        end
    end

    // Output buffer control: main entry plus one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_xfer)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_xfer;
                out_data_next  = result;
            end
        end
        else if (in_xfer)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
